// ----- rtl/tclp_pkg.sv -----
// Shared types and character constants of the taxon count list parser.
`timescale 1ns / 1ps

package tclp_pkg;

  localparam int OUT_W = 32;
  localparam int LEN_W = 5;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_ORDINARY = 2'd0;
  localparam kind_t KIND_AMBIG    = 2'd1;
  localparam kind_t KIND_MATE     = 2'd2;
  localparam kind_t KIND_FRAME    = 2'd3;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_BAR   = 8'h7C;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam logic [OUT_W-1:0] SENT_AMBIG = 32'd2147483647;
  localparam logic [OUT_W-1:0] SENT_MATE  = 32'd2147483646;
  localparam logic [OUT_W-1:0] SENT_FRAME = 32'd2147483645;

  typedef struct packed {
    kind_t            kind;
    logic [OUT_W-1:0] taxon_id;
    logic [OUT_W-1:0] hit_count;
  } result_t;

endpackage

// ----- rtl/taxon_count_list_parser_unit.sv -----
// Top level of the taxon count list parser: input register, parser, result register.
//
//  channel  | direction | tdata                      | tuser      | tlast
//  in_      | slave     | [7:0] text_byte            | -          | final_byte
//  out_     | master     | [31:0] taxon_id, [63:32] hit_count | [1:0] entry_kind | -
//
//  One byte per clock sustained while no result is held waiting; each result
//  passes through the input register and the result register around the parser.
//  Synchronous active-low reset returns the parser to the start of an id token.
//  A waiting result holds the parser, even for a byte that emits nothing; an
//  empty input register still takes one transaction, after that in_tready
//  stays low until the result is taken, so an output stall also stalls the input.
`timescale 1ns / 1ps

module taxon_count_list_parser_unit #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] taxon_id, [63:32] hit_count
  output logic [1:0]  out_tuser   // [1:0] entry_kind
);
  import tclp_pkg::*;

  logic       in_valid_r;
  logic [7:0] char_r;
  logic       final_r;
  logic       out_valid_r;
  result_t    result_r;

  logic       slot_free;
  logic       step;
  logic       emit;
  result_t    result;

  assign slot_free = !out_valid_r || out_tready;
  assign step      = in_valid_r && slot_free;
  assign in_tready = !in_valid_r || slot_free;

  tclp_parser #(.VALUE_WIDTH(VALUE_WIDTH), .MAX_DIGITS(MAX_DIGITS)) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .char_in  (char_r),
    .final_in (final_r),
    .emit     (emit),
    .result   (result)
  );

  // hold the input transaction until the parser consumes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      char_r  <= in_tdata;
      final_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {result_r.hit_count, result_r.taxon_id};
  assign out_tuser  = result_r.kind;

endmodule

// ----- rtl/tclp_token_acc.sv -----
// Decimal token accumulator step: value*10 + (byte - '0') and saturating length.
`timescale 1ns / 1ps

module tclp_token_acc #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 20
) (
  input  logic [VALUE_WIDTH-1:0]     val,
  input  logic [tclp_pkg::LEN_W-1:0] len,
  input  logic [7:0]                 char_in,
  output logic [VALUE_WIDTH-1:0]     val_nxt,
  output logic [tclp_pkg::LEN_W-1:0] len_nxt
);
  import tclp_pkg::*;

  logic [VALUE_WIDTH-1:0] times_ten;
  logic [VALUE_WIDTH-1:0] char_ext;

  assign times_ten = (val << 3) + (val << 1);
  assign char_ext  = VALUE_WIDTH'(char_in);
  assign val_nxt   = times_ten + char_ext - VALUE_WIDTH'(CHAR_ZERO);
  assign len_nxt   = (len > LEN_W'(MAX_DIGITS)) ? len : len + LEN_W'(1);

endmodule

// ----- rtl/tclp_parser.sv -----
// Pair parser: token state, phase tracking and result formatting.
`timescale 1ns / 1ps

module tclp_parser #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        char_in,
  input  logic              final_in,
  output logic              emit,
  output tclp_pkg::result_t result
);
  import tclp_pkg::*;

  logic                   in_count_r, in_count_nxt;
  kind_t                  kind_r, kind_nxt;
  logic [VALUE_WIDTH-1:0] id_acc_r, id_acc_nxt;
  logic [VALUE_WIDTH-1:0] cnt_acc_r, cnt_acc_nxt;
  logic [LEN_W-1:0]       id_len_r, id_len_nxt;
  logic [LEN_W-1:0]       cnt_len_r, cnt_len_nxt;

  logic [VALUE_WIDTH-1:0] id_step_val, cnt_step_val;
  logic [LEN_W-1:0]       id_step_len, cnt_step_len;
  logic [VALUE_WIDTH-1:0] id_eff, cnt_eff;
  logic [OUT_W-1:0]       id_out, cnt_out;
  kind_t                  first_kind;

  tclp_token_acc #(.VALUE_WIDTH(VALUE_WIDTH), .MAX_DIGITS(MAX_DIGITS)) u_id_acc (
    .val     (id_acc_r),
    .len     (id_len_r),
    .char_in (char_in),
    .val_nxt (id_step_val),
    .len_nxt (id_step_len)
  );

  tclp_token_acc #(.VALUE_WIDTH(VALUE_WIDTH), .MAX_DIGITS(MAX_DIGITS)) u_cnt_acc (
    .val     (cnt_acc_r),
    .len     (cnt_len_r),
    .char_in (char_in),
    .val_nxt (cnt_step_val),
    .len_nxt (cnt_step_len)
  );

  always_comb begin
    unique case (char_in)
      CHAR_A:    first_kind = KIND_AMBIG;
      CHAR_BAR:  first_kind = KIND_MATE;
      CHAR_DASH: first_kind = KIND_FRAME;
      default:   first_kind = KIND_ORDINARY;
    endcase
  end

  // count is zero when the list ends on the colon of an id
  assign id_eff  = (id_len_r > LEN_W'(MAX_DIGITS)) ? '0 : id_acc_r;
  assign cnt_eff = (!in_count_r || cnt_len_r > LEN_W'(MAX_DIGITS)) ? '0 : cnt_acc_r;

  generate
    if (VALUE_WIDTH >= OUT_W) begin : g_trunc
      assign id_out  = id_eff[OUT_W-1:0];
      assign cnt_out = cnt_eff[OUT_W-1:0];
    end else begin : g_extend
      assign id_out  = {{(OUT_W-VALUE_WIDTH){1'b0}}, id_eff};
      assign cnt_out = {{(OUT_W-VALUE_WIDTH){1'b0}}, cnt_eff};
    end
  endgenerate

  always_comb begin
    result.kind = kind_r;
    unique case (kind_r)
      KIND_AMBIG: begin
        result.taxon_id  = SENT_AMBIG;
        result.hit_count = cnt_out;
      end
      KIND_MATE: begin
        result.taxon_id  = SENT_MATE;
        result.hit_count = SENT_MATE;
      end
      KIND_FRAME: begin
        result.taxon_id  = SENT_FRAME;
        result.hit_count = SENT_FRAME;
      end
      default: begin
        result.taxon_id  = id_out;
        result.hit_count = cnt_out;
      end
    endcase
  end

  always_comb begin
    in_count_nxt = in_count_r;
    kind_nxt     = kind_r;
    id_acc_nxt   = id_acc_r;
    cnt_acc_nxt  = cnt_acc_r;
    id_len_nxt   = id_len_r;
    cnt_len_nxt  = cnt_len_r;
    emit         = 1'b0;
    if (final_in) begin
      emit         = in_count_r || (char_in == CHAR_COLON);
      in_count_nxt = 1'b0;
      kind_nxt     = KIND_ORDINARY;
      id_acc_nxt   = '0;
      cnt_acc_nxt  = '0;
      id_len_nxt   = '0;
      cnt_len_nxt  = '0;
    end else if (!in_count_r) begin
      if (char_in == CHAR_COLON) begin
        in_count_nxt = 1'b1;
        cnt_acc_nxt  = '0;
        cnt_len_nxt  = '0;
      end else begin
        if (id_len_r == '0) begin
          kind_nxt = first_kind;
        end
        id_acc_nxt = id_step_val;
        id_len_nxt = id_step_len;
      end
    end else if (char_in == CHAR_SPACE) begin
      emit         = 1'b1;
      in_count_nxt = 1'b0;
      kind_nxt     = KIND_ORDINARY;
      id_acc_nxt   = '0;
      cnt_acc_nxt  = '0;
      id_len_nxt   = '0;
      cnt_len_nxt  = '0;
    end else begin
      cnt_acc_nxt = cnt_step_val;
      cnt_len_nxt = cnt_step_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_count_r <= 1'b0;
      kind_r     <= KIND_ORDINARY;
      id_acc_r   <= '0;
      cnt_acc_r  <= '0;
      id_len_r   <= '0;
      cnt_len_r  <= '0;
    end else if (step) begin
      in_count_r <= in_count_nxt;
      kind_r     <= kind_nxt;
      id_acc_r   <= id_acc_nxt;
      cnt_acc_r  <= cnt_acc_nxt;
      id_len_r   <= id_len_nxt;
      cnt_len_r  <= cnt_len_nxt;
    end
  end

endmodule

// ----- verif/tb_taxon_count_list_parser_unit.sv -----
// Self-checking testbench of the taxon count list parser: directed and random byte lists.
`timescale 1ns / 1ps

module tb_taxon_count_list_parser_unit;
  import tclp_pkg::*;

  localparam int MAX_TOKEN    = 20;
  localparam int RANDOM_ITEMS = 1250;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 12;
  localparam int LIMIT_CYCLES = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] text_byte
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [31:0] taxon_id, [63:32] hit_count
  logic [1:0]  out_tuser;  // [1:0] entry_kind

  taxon_count_list_parser_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // parser state mirror
  logic        count_phase;
  kind_t       pair_kind;
  logic [31:0] id_value;
  logic [31:0] count_value;
  logic [4:0]  id_len;
  logic [4:0]  count_len;

  result_t     expected_pairs[$];
  int          error_count;
  int          bytes_sent;
  int          cycle_count;
  bit          sender_idle_on;
  bit          receiver_idle_on;
  logic        hold_active;
  event        hold_start;

  function automatic logic [31:0] shift_in_char(logic [31:0] v, logic [7:0] ch);
    return v * 32'd10 + {24'd0, ch} - {24'd0, CHAR_ZERO};
  endfunction

  function automatic logic [4:0] bump_length(logic [4:0] n);
    return (n > MAX_TOKEN) ? n : n + 5'd1;
  endfunction

  function automatic result_t finished_pair();
    result_t r;
    r.kind      = pair_kind;
    r.taxon_id  = (id_len > MAX_TOKEN) ? 32'd0 : id_value;
    r.hit_count = (count_len > MAX_TOKEN) ? 32'd0 : count_value;
    case (pair_kind)
      KIND_AMBIG: r.taxon_id = SENT_AMBIG;
      KIND_MATE: begin
        r.taxon_id  = SENT_MATE;
        r.hit_count = SENT_MATE;
      end
      KIND_FRAME: begin
        r.taxon_id  = SENT_FRAME;
        r.hit_count = SENT_FRAME;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic append_expected(input result_t r);
    expected_pairs = {expected_pairs, r};
  endtask

  task automatic clear_parser();
    count_phase = 1'b0;
    pair_kind   = KIND_ORDINARY;
    id_value    = '0;
    count_value = '0;
    id_len      = '0;
    count_len   = '0;
  endtask

  task automatic predict_byte(input logic [7:0] ch, input logic fin);
    if (fin) begin
      if (count_phase) begin
        append_expected(finished_pair());
      end else if (ch == CHAR_COLON) begin
        count_value = '0;
        count_len   = '0;
        append_expected(finished_pair());
      end
      clear_parser();
    end else if (!count_phase) begin
      if (ch == CHAR_COLON) begin
        count_phase = 1'b1;
        count_value = '0;
        count_len   = '0;
      end else begin
        if (id_len == 0) begin
          if (ch == CHAR_A) pair_kind = KIND_AMBIG;
          else if (ch == CHAR_BAR) pair_kind = KIND_MATE;
          else if (ch == CHAR_DASH) pair_kind = KIND_FRAME;
          else pair_kind = KIND_ORDINARY;
        end
        id_value = shift_in_char(id_value, ch);
        id_len   = bump_length(id_len);
      end
    end else if (ch == CHAR_SPACE) begin
      append_expected(finished_pair());
      clear_parser();
    end else begin
      count_value = shift_in_char(count_value, ch);
      count_len   = bump_length(count_len);
    end
  endtask

  task automatic check_pair(input kind_t kind, input logic [63:0] data);
    result_t want;
    if (expected_pairs.size() == 0) begin
      $display("%0t: unexpected result: kind %0d id %0d count %0d", $time, kind,
               data[31:0], data[63:32]);
      error_count++;
    end else begin
      want = expected_pairs.pop_front();
      if (kind !== want.kind) begin
        $display("%0t: entry_kind mismatch: expected %0d, actual %0d", $time, want.kind, kind);
        error_count++;
      end
      if (data[31:0] !== want.taxon_id) begin
        $display("%0t: taxon_id mismatch: expected %0d, actual %0d", $time, want.taxon_id,
                 data[31:0]);
        error_count++;
      end
      if (data[63:32] !== want.hit_count) begin
        $display("%0t: hit_count mismatch: expected %0d, actual %0d", $time, want.hit_count,
                 data[63:32]);
        error_count++;
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] ch, input logic fin);
    int gap;
    gap = sender_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    predict_byte(ch, fin);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] random_digit();
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] random_text_char();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : random_digit();
  endfunction

  function automatic int token_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(19, 24) : $urandom_range(0, 10);
  endfunction

  task automatic send_random_pair();
    logic [7:0] lead;
    int         n;
    case ($urandom_range(0, 9))
      0: lead = CHAR_A;
      1: lead = CHAR_BAR;
      2: lead = CHAR_DASH;
      default: lead = random_text_char();
    endcase
    n = token_length();
    if (n > 0) begin
      send_byte(lead, 1'b0);
      repeat (n - 1) send_byte(random_text_char(), 1'b0);
    end
    send_byte(CHAR_COLON, 1'b0);
    n = token_length();
    repeat (n) send_byte(random_text_char(), 1'b0);
    send_byte(CHAR_SPACE, 1'b0);
  endtask

  task automatic send_random_list();
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_random_pair();
    end
    case ($urandom_range(0, 3))
      0: begin
        repeat ($urandom_range(0, 3)) send_byte(random_digit(), 1'b0);
        send_byte(CHAR_COLON, 1'b1);
      end
      1: begin
        send_byte(random_digit(), 1'b0);
        send_byte(CHAR_COLON, 1'b0);
        repeat ($urandom_range(0, 3)) send_byte(random_digit(), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      2: begin
        repeat ($urandom_range(1, 4)) send_byte(random_digit(), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      default: send_byte(8'($urandom_range(0, 255)), 1'b1);
    endcase
  endtask

  task automatic test_marker_kinds();
    send_text("A5:7 |:1 -: :3 ");
  endtask

  task automatic test_odd_bytes();
    send_byte(8'hFF, 1'b0);
    send_byte(CHAR_COLON, 1'b0);
    send_byte(CHAR_COLON, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CHAR_SPACE, 1'b0);
    send_byte(CHAR_SPACE, 1'b0);
    send_byte(CHAR_COLON, 1'b1);
  endtask

  task automatic test_list_close();
    send_text("3:8");
    send_byte("x", 1'b1);
    send_text("4");
    send_byte("5", 1'b1);
  endtask

  task automatic test_result_backpressure();
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    -> hold_start;
    repeat (12) begin
      send_byte(random_digit(), 1'b0);
      send_byte(CHAR_COLON, 1'b0);
      send_byte(random_digit(), 1'b0);
      send_byte(CHAR_SPACE, 1'b0);
    end
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
  endtask

  task automatic test_random_lists();
    int stop_at;
    stop_at = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < stop_at) begin
      sender_idle_on   = ($urandom_range(0, 3) != 0);
      receiver_idle_on = ($urandom_range(0, 3) != 0);
      send_random_list();
    end
  endtask

  initial begin : result_sink
    int wait_cycles;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      wait_cycles = receiver_idle_on ? $urandom_range(0, 4) : 0;
      if (wait_cycles > 0 || hold_active) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
        while (hold_active) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      check_pair(out_tuser, out_tdata);
    end
  end

  initial begin : result_hold_off
    hold_active <= 1'b0;
    forever begin
      @(hold_start);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    error_count      = 0;
    bytes_sent       = 0;
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    clear_parser();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_marker_kinds();
    test_odd_bytes();
    test_list_close();
    test_result_backpressure();
    test_random_lists();

    in_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tclp_pkg.sv
rtl/tclp_token_acc.sv
rtl/tclp_parser.sv
rtl/taxon_count_list_parser_unit.sv
verif/tb_taxon_count_list_parser_unit.sv
